>>> hw/rtl/cpu8ie_pkg.sv
`default_nettype none
package cpu8ie_pkg;

  localparam int OP_W = 6;
  localparam int DATA_W = 8;

  localparam logic [OP_W-1:0] OP_LDA = 6'd0;
  localparam logic [OP_W-1:0] OP_STA = 6'd1;
  localparam logic [OP_W-1:0] OP_LDX = 6'd2;
  localparam logic [OP_W-1:0] OP_STX = 6'd3;
  localparam logic [OP_W-1:0] OP_LDY = 6'd4;
  localparam logic [OP_W-1:0] OP_STY = 6'd5;
  localparam logic [OP_W-1:0] OP_TAX = 6'd6;
  localparam logic [OP_W-1:0] OP_TXA = 6'd7;
  localparam logic [OP_W-1:0] OP_TAY = 6'd8;
  localparam logic [OP_W-1:0] OP_TYA = 6'd9;
  localparam logic [OP_W-1:0] OP_ADC = 6'd10;
  localparam logic [OP_W-1:0] OP_SBC = 6'd11;
  localparam logic [OP_W-1:0] OP_INC = 6'd12;
  localparam logic [OP_W-1:0] OP_DEC = 6'd13;
  localparam logic [OP_W-1:0] OP_INX = 6'd14;
  localparam logic [OP_W-1:0] OP_DEX = 6'd15;
  localparam logic [OP_W-1:0] OP_INY = 6'd16;
  localparam logic [OP_W-1:0] OP_DEY = 6'd17;
  localparam logic [OP_W-1:0] OP_ASL = 6'd18;
  localparam logic [OP_W-1:0] OP_LSR = 6'd19;
  localparam logic [OP_W-1:0] OP_ROL = 6'd20;
  localparam logic [OP_W-1:0] OP_ROR = 6'd21;
  localparam logic [OP_W-1:0] OP_ORA = 6'd22;
  localparam logic [OP_W-1:0] OP_AND = 6'd23;
  localparam logic [OP_W-1:0] OP_EOR = 6'd24;
  localparam logic [OP_W-1:0] OP_BIT = 6'd25;
  localparam logic [OP_W-1:0] OP_CMP = 6'd26;
  localparam logic [OP_W-1:0] OP_CPX = 6'd27;
  localparam logic [OP_W-1:0] OP_CPY = 6'd28;
  localparam logic [OP_W-1:0] OP_BCC = 6'd29;
  localparam logic [OP_W-1:0] OP_BCS = 6'd30;
  localparam logic [OP_W-1:0] OP_BEQ = 6'd31;
  localparam logic [OP_W-1:0] OP_BNE = 6'd32;
  localparam logic [OP_W-1:0] OP_BPL = 6'd33;
  localparam logic [OP_W-1:0] OP_BMI = 6'd34;
  localparam logic [OP_W-1:0] OP_BVC = 6'd35;
  localparam logic [OP_W-1:0] OP_BVS = 6'd36;
  localparam logic [OP_W-1:0] OP_CLC = 6'd37;
  localparam logic [OP_W-1:0] OP_SEC = 6'd38;
  localparam logic [OP_W-1:0] OP_CLI = 6'd39;
  localparam logic [OP_W-1:0] OP_SEI = 6'd40;
  localparam logic [OP_W-1:0] OP_CLD = 6'd41;
  localparam logic [OP_W-1:0] OP_SED = 6'd42;
  localparam logic [OP_W-1:0] OP_CLV = 6'd43;
  localparam logic [OP_W-1:0] OP_NOP = 6'd44;
  localparam logic [OP_W-1:0] OP_STP = 6'd45;

  // branch flag select
  localparam logic [1:0] BR_C = 2'd0;
  localparam logic [1:0] BR_Z = 2'd1;
  localparam logic [1:0] BR_N = 2'd2;
  localparam logic [1:0] BR_V = 2'd3;

  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] mem_value;
    logic              store_en;
    logic              is_branch;
    logic [1:0]        br_sel;
    logic              br_pol;
  } dec_t;

  typedef struct packed {
    logic [DATA_W-1:0] store_value;
    logic              store_enable;
    logic              branch_taken;
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] xreg;
    logic [DATA_W-1:0] yreg;
    logic [DATA_W-1:0] status;
    logic              halted;
  } res_t;

endpackage
`default_nettype wire

>>> hw/rtl/cpu8_instruction_execute_top.sv
`default_nettype none
// 6502-style execute unit: one operation per transaction, one result per
// transaction, in order. Sustained rate is one transaction per cycle while
// neither the push side nor the pop side stalls; a transaction pushed into
// an idle block passes the decode register, then the decode queue; the
// execute stage works straight off the decode queue head and writes the
// result queue. Execution is serialized through the single execute stage,
// which owns A, X, Y, the flags and the halt flag; the decode queue and the
// result queue let the push and pop sides stall independently. After STP
// every later transaction reports the held state until reset.
module cpu8_instruction_execute_top
  import cpu8ie_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int OUT_DEPTH   = OUT_DEPTH_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  output logic              full,
  input  wire  [OP_W-1:0]   opcode,
  input  wire  [DATA_W-1:0] mem_value,
  output logic              empty,
  input  wire               pop,
  output logic [DATA_W-1:0] store_value,
  output logic              store_enable,
  output logic              branch_taken,
  output logic [DATA_W-1:0] acc_out,
  output logic [DATA_W-1:0] xreg_out,
  output logic [DATA_W-1:0] yreg_out,
  output logic [DATA_W-1:0] status_out,
  output logic              halted_out
);

  logic dec_valid, dec_ready;
  dec_t dec_data;
  logic q_full, q_empty, q_pop;
  dec_t q_data;
  logic res_push, res_full;
  res_t res_in, res_out;

  cpu8ie_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .opcode    (opcode),
    .mem_value (mem_value),
    .full      (full),
    .dec_valid (dec_valid),
    .dec_data  (dec_data),
    .dec_ready (dec_ready)
  );

  assign dec_ready = !q_full;

  cpu8ie_fifo #(.T(dec_t), .DEPTH(QUEUE_DEPTH)) u_dec_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (dec_valid),
    .din   (dec_data),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_data),
    .empty (q_empty)
  );

  cpu8ie_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!q_empty),
    .in_data  (q_data),
    .in_ready (q_pop),
    .res_push (res_push),
    .res_data (res_in),
    .res_full (res_full)
  );

  cpu8ie_fifo #(.T(res_t), .DEPTH(OUT_DEPTH)) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign store_value  = res_out.store_value;
  assign store_enable = res_out.store_enable;
  assign branch_taken = res_out.branch_taken;
  assign acc_out      = res_out.acc;
  assign xreg_out     = res_out.xreg;
  assign yreg_out     = res_out.yreg;
  assign status_out   = res_out.status;
  assign halted_out   = res_out.halted;

endmodule
`default_nettype wire

>>> hw/rtl/cpu8ie_fifo.sv
`default_nettype none
module cpu8ie_fifo #(
  parameter type T = logic,
  parameter int DEPTH = 2
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  push,
  input  T     din,
  output logic full,
  input  wire  pop,
  output T     dout,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T               mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/cpu8ie_front.sv
`default_nettype none
module cpu8ie_front
  import cpu8ie_pkg::*;
(
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  wire  [OP_W-1:0]   opcode,
  input  wire  [DATA_W-1:0] mem_value,
  output logic              full,
  output logic              dec_valid,
  output dec_t              dec_data,
  input  wire               dec_ready
);

  logic valid;
  dec_t dec;
  dec_t dec_next;

  always_comb begin
    dec_next           = '0;
    dec_next.mem_value = mem_value;
    // unused codes collapse to NOP
    dec_next.op        = (opcode > OP_STP) ? OP_NOP : opcode;
    dec_next.store_en  = opcode inside {OP_STA, OP_STX, OP_STY, [OP_INC:OP_DEC],
                                        [OP_ASL:OP_ROR]};
    dec_next.is_branch = opcode inside {[OP_BCC:OP_BVS]};
    case (opcode)
      OP_BCC:  begin dec_next.br_sel = BR_C; dec_next.br_pol = 1'b0; end
      OP_BCS:  begin dec_next.br_sel = BR_C; dec_next.br_pol = 1'b1; end
      OP_BEQ:  begin dec_next.br_sel = BR_Z; dec_next.br_pol = 1'b1; end
      OP_BNE:  begin dec_next.br_sel = BR_Z; dec_next.br_pol = 1'b0; end
      OP_BPL:  begin dec_next.br_sel = BR_N; dec_next.br_pol = 1'b0; end
      OP_BMI:  begin dec_next.br_sel = BR_N; dec_next.br_pol = 1'b1; end
      OP_BVC:  begin dec_next.br_sel = BR_V; dec_next.br_pol = 1'b0; end
      OP_BVS:  begin dec_next.br_sel = BR_V; dec_next.br_pol = 1'b1; end
      default: begin dec_next.br_sel = BR_C; dec_next.br_pol = 1'b0; end
    endcase
  end

  assign full      = valid && !dec_ready;
  assign dec_valid = valid;
  assign dec_data  = dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!full) begin
      valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      dec <= dec_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/cpu8ie_back.sv
`default_nettype none
module cpu8ie_back
  import cpu8ie_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  input  dec_t in_data,
  output logic in_ready,
  output logic res_push,
  output res_t res_data,
  input  wire  res_full
);

  logic [DATA_W-1:0] acc, xreg, yreg;
  logic              carry, zero, negative, overflow, irq_dis, decimal, halted;

  logic [DATA_W-1:0] acc_next, xreg_next, yreg_next;
  logic              carry_next, zero_next, negative_next, overflow_next;
  logic              irq_dis_next, decimal_next, halted_next;

  logic [DATA_W-1:0] m;
  logic [DATA_W-1:0] addend;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] cmp_reg;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] sv;
  logic              br_flag;
  logic              fire;

  assign fire     = in_valid && !res_full;
  assign in_ready = !res_full;
  assign m        = in_data.mem_value;
  assign addend   = (in_data.op == OP_SBC) ? ~m : m;
  assign sum      = {1'b0, acc} + {1'b0, addend} + {{DATA_W{1'b0}}, carry};

  always_comb begin
    case (in_data.op)
      OP_CPX:  cmp_reg = xreg;
      OP_CPY:  cmp_reg = yreg;
      default: cmp_reg = acc;
    endcase
  end

  assign diff = {1'b0, cmp_reg} - {1'b0, m};

  always_comb begin
    case (in_data.br_sel)
      BR_C:    br_flag = carry;
      BR_Z:    br_flag = zero;
      BR_N:    br_flag = negative;
      default: br_flag = overflow;
    endcase
  end

  always_comb begin
    acc_next      = acc;
    xreg_next     = xreg;
    yreg_next     = yreg;
    carry_next    = carry;
    zero_next     = zero;
    negative_next = negative;
    overflow_next = overflow;
    irq_dis_next  = irq_dis;
    decimal_next  = decimal;
    halted_next   = halted;
    sv            = '0;
    if (!halted) begin
      case (in_data.op)
        OP_LDA: acc_next  = m;
        OP_STA: sv        = acc;
        OP_LDX: xreg_next = m;
        OP_STX: sv        = xreg;
        OP_LDY: yreg_next = m;
        OP_STY: sv        = yreg;
        OP_TAX: xreg_next = acc;
        OP_TXA: acc_next  = xreg;
        OP_TAY: yreg_next = acc;
        OP_TYA: acc_next  = yreg;
        OP_ADC, OP_SBC: begin
          acc_next      = sum[DATA_W-1:0];
          carry_next    = sum[DATA_W];
          overflow_next = (acc[DATA_W-1] ^ sum[DATA_W-1]) &
                          (addend[DATA_W-1] ^ sum[DATA_W-1]);
        end
        OP_INC: sv        = m + 8'd1;
        OP_DEC: sv        = m - 8'd1;
        OP_INX: xreg_next = xreg + 8'd1;
        OP_DEX: xreg_next = xreg - 8'd1;
        OP_INY: yreg_next = yreg + 8'd1;
        OP_DEY: yreg_next = yreg - 8'd1;
        OP_ASL: begin sv = {m[6:0], 1'b0};  carry_next = m[7]; end
        OP_LSR: begin sv = {1'b0, m[7:1]};  carry_next = m[0]; end
        OP_ROL: begin sv = {m[6:0], carry}; carry_next = m[7]; end
        OP_ROR: begin sv = {carry, m[7:1]}; carry_next = m[0]; end
        OP_ORA: acc_next = acc | m;
        OP_AND: acc_next = acc & m;
        OP_EOR: acc_next = acc ^ m;
        OP_BIT: begin
          zero_next     = ((acc & m) == '0);
          overflow_next = m[6];
          negative_next = m[7];
        end
        OP_CMP, OP_CPX, OP_CPY: begin
          carry_next    = !diff[DATA_W];
          zero_next     = (cmp_reg == m);
          negative_next = diff[DATA_W-1];
        end
        OP_CLC: carry_next    = 1'b0;
        OP_SEC: carry_next    = 1'b1;
        OP_CLI: irq_dis_next  = 1'b0;
        OP_SEI: irq_dis_next  = 1'b1;
        OP_CLD: decimal_next  = 1'b0;
        OP_SED: decimal_next  = 1'b1;
        OP_CLV: overflow_next = 1'b0;
        OP_STP: halted_next   = 1'b1;
        default: ;
      endcase
      // Z/N from the written value
      case (in_data.op)
        OP_LDA, OP_TXA, OP_TYA, OP_ADC, OP_SBC, OP_ORA, OP_AND, OP_EOR: begin
          zero_next     = (acc_next == '0);
          negative_next = acc_next[7];
        end
        OP_LDX, OP_TAX, OP_INX, OP_DEX: begin
          zero_next     = (xreg_next == '0);
          negative_next = xreg_next[7];
        end
        OP_LDY, OP_TAY, OP_INY, OP_DEY: begin
          zero_next     = (yreg_next == '0);
          negative_next = yreg_next[7];
        end
        OP_INC, OP_DEC, OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
          zero_next     = (sv == '0);
          negative_next = sv[7];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_data.store_enable = in_data.store_en && !halted;
    res_data.store_value  = res_data.store_enable ? sv : '0;
    res_data.branch_taken = in_data.is_branch && !halted && (br_flag == in_data.br_pol);
    res_data.acc          = acc_next;
    res_data.xreg         = xreg_next;
    res_data.yreg         = yreg_next;
    res_data.status       = {negative_next, overflow_next, 1'b1, 1'b0,
                             decimal_next, irq_dis_next, zero_next, carry_next};
    res_data.halted       = halted_next;
  end

  assign res_push = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      xreg     <= '0;
      yreg     <= '0;
      carry    <= 1'b0;
      zero     <= 1'b0;
      negative <= 1'b0;
      overflow <= 1'b0;
      irq_dis  <= 1'b1;
      decimal  <= 1'b0;
      halted   <= 1'b0;
    end else if (fire) begin
      acc      <= acc_next;
      xreg     <= xreg_next;
      yreg     <= yreg_next;
      carry    <= carry_next;
      zero     <= zero_next;
      negative <= negative_next;
      overflow <= overflow_next;
      irq_dis  <= irq_dis_next;
      decimal  <= decimal_next;
      halted   <= halted_next;
    end
  end

endmodule
`default_nettype wire
